@@ rtl/packbits_run_length_decoder_unit_assert.svh @@
// ----------------------------------------------------------------------------
// PackBits decoder assertion macros
// Shared property macros for the decoder's internal checks.
// ----------------------------------------------------------------------------
`ifndef PACKBITS_RUN_LENGTH_DECODER_UNIT_ASSERT_SVH
`define PACKBITS_RUN_LENGTH_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define PBRLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PBRLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/pbrld_pkg.sv @@
// ----------------------------------------------------------------------------
// PackBits decoder package
// Types and constants shared by the decoder's front, queue and back.
// ----------------------------------------------------------------------------
package pbrld_pkg;

   localparam int ROW_LEN_BITS   = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CONSUMED_BITS  = 18;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SKIP_CODE   = 8'd128;
   localparam logic [8:0] REPEAT_BASE = 9'd257;
   localparam logic [CONSUMED_BITS-1:0] CONSUMED_MAX = {CONSUMED_BITS{1'b1}};

   typedef logic [ROW_LEN_BITS-1:0]  row_len_type;
   typedef logic [ROW_LEN_BITS:0]    row_sum_type;
   typedef logic [CONSUMED_BITS-1:0] consumed_type;

   typedef enum logic [1:0] {
      PH_CONTROL = 2'd0,
      PH_LITERAL = 2'd1,
      PH_REPEAT  = 2'd2
   } phase_type;

   typedef enum logic {
      OP_RUN   = 1'b0,
      OP_ERROR = 1'b1
   } op_type;

   typedef struct packed {
      op_type       op;
      logic [7:0]   data_byte;
      logic [7:0]   repeat_count;
      logic         row_last;
      consumed_type consumed_bytes;
   } entry_type;

endpackage

@@ rtl/pbrld_front.sv @@
// ----------------------------------------------------------------------------
// PackBits decoder front end
// Takes one compressed byte per cycle unless stalled, tracks run state and
// hands each result-producing byte to the queue as a run or error entry.
// ----------------------------------------------------------------------------
module pbrld_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [7:0]             req_code_byte,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [pbrld_pkg::CSR_DATA_BITS-1:0] csr_row_length,
   output logic                   push_valid,
   output pbrld_pkg::entry_type   push_entry
);

   pbrld_pkg::phase_type    phase_ff, phase_in;
   logic [7:0]              run_left_ff, run_left_in;
   pbrld_pkg::row_len_type  written_ff, written_in;
   pbrld_pkg::consumed_type consumed_ff, consumed_in;
   pbrld_pkg::row_len_type  row_length_ff, row_length_in;

   logic                    accept;
   logic                    is_literal, is_repeat, is_control;
   logic                    ctl_literal, ctl_skip;
   logic [7:0]              lit_len, rep_len, run_dec, len;
   pbrld_pkg::row_sum_type  sum;
   logic                    over, fills;
   logic                    err, run_emit, restart;
   pbrld_pkg::consumed_type cons_inc;

   assign accept      = req_valid && !req_stall;
   assign is_literal  = (phase_ff == pbrld_pkg::PH_LITERAL);
   assign is_repeat   = (phase_ff == pbrld_pkg::PH_REPEAT);
   assign is_control  = !is_literal && !is_repeat;
   assign ctl_literal = !req_code_byte[7];
   assign ctl_skip    = (req_code_byte == pbrld_pkg::SKIP_CODE);
   assign lit_len     = {1'b0, req_code_byte[6:0]} + 8'd1;
   assign rep_len     = 8'(pbrld_pkg::REPEAT_BASE - {1'b0, req_code_byte});
   assign run_dec     = run_left_ff - 8'd1;
   assign len         = is_literal ? 8'd1 : (is_repeat ? run_left_ff : lit_len);
   assign sum         = {1'b0, written_ff} + pbrld_pkg::row_sum_type'(len);
   assign over        = sum > {1'b0, row_length_ff};
   assign fills       = sum == {1'b0, row_length_ff};
   assign err         = (is_repeat && over) || (is_control && ctl_literal && over);
   assign run_emit    = is_literal || (is_repeat && !over);
   assign restart     = err || (run_emit && fills);
   assign cons_inc    = (consumed_ff == pbrld_pkg::CONSUMED_MAX)
                        ? consumed_ff
                        : consumed_ff + pbrld_pkg::consumed_type'(1);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            pbrld_pkg::PH_LITERAL: begin
               phase_in = (run_dec == 8'd0) ? pbrld_pkg::PH_CONTROL
                                            : pbrld_pkg::PH_LITERAL;
            end
            pbrld_pkg::PH_REPEAT: begin
               phase_in = pbrld_pkg::PH_CONTROL;
            end
            default: begin
               if (ctl_literal) begin
                  phase_in = pbrld_pkg::PH_LITERAL;
               end else if (ctl_skip) begin
                  phase_in = pbrld_pkg::PH_CONTROL;
               end else begin
                  phase_in = pbrld_pkg::PH_REPEAT;
               end
            end
         endcase
         if (restart) begin
            phase_in = pbrld_pkg::PH_CONTROL;
         end
      end
   end

   // counters and queue entry
   always_comb begin
      run_left_in = run_left_ff;
      written_in  = written_ff;
      consumed_in = consumed_ff;
      push_valid  = 1'b0;
      push_entry.op             = err ? pbrld_pkg::OP_ERROR : pbrld_pkg::OP_RUN;
      push_entry.data_byte      = req_code_byte;
      push_entry.repeat_count   = len;
      push_entry.row_last       = fills;
      push_entry.consumed_bytes = cons_inc;
      if (accept) begin
         consumed_in = cons_inc;
         push_valid  = err || run_emit;
         unique case (phase_ff)
            pbrld_pkg::PH_LITERAL: begin
               run_left_in = run_dec;
            end
            pbrld_pkg::PH_REPEAT: begin
               run_left_in = 8'd0;
            end
            default: begin
               if (ctl_literal) begin
                  run_left_in = lit_len;
               end else if (!ctl_skip) begin
                  run_left_in = rep_len;
               end
            end
         endcase
         if (run_emit) begin
            written_in = sum[pbrld_pkg::ROW_LEN_BITS-1:0];
         end
         if (restart) begin
            run_left_in = 8'd0;
            written_in  = '0;
            consumed_in = '0;
         end
      end
   end

   always_comb begin
      row_length_in = row_length_ff;
      if (csr_valid && csr_ready) begin
         row_length_in = pbrld_pkg::row_len_type'(csr_row_length);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= pbrld_pkg::PH_CONTROL;
         run_left_ff   <= 8'd0;
         written_ff    <= '0;
         consumed_ff   <= '0;
         row_length_ff <= pbrld_pkg::row_len_type'(1);
      end else begin
         phase_ff      <= phase_in;
         run_left_ff   <= run_left_in;
         written_ff    <= written_in;
         consumed_ff   <= consumed_in;
         row_length_ff <= row_length_in;
      end
   end

endmodule

@@ rtl/pbrld_queue.sv @@
// ----------------------------------------------------------------------------
// PackBits decoder entry queue
// Short FIFO between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module pbrld_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  pbrld_pkg::entry_type push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 q_valid,
   output pbrld_pkg::entry_type q_entry
);

   pbrld_pkg::entry_type                  slot_ff [pbrld_pkg::QUEUE_DEPTH];
   logic [pbrld_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [pbrld_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [pbrld_pkg::QUEUE_CNT_BITS-1:0]  count_ff, count_in;
   logic                                  do_push, do_pop;

   localparam logic [pbrld_pkg::QUEUE_PTR_BITS-1:0] LastPtr =
      pbrld_pkg::QUEUE_PTR_BITS'(pbrld_pkg::QUEUE_DEPTH - 1);
   localparam logic [pbrld_pkg::QUEUE_CNT_BITS-1:0] FullCount =
      pbrld_pkg::QUEUE_CNT_BITS'(pbrld_pkg::QUEUE_DEPTH);

   assign full    = (count_ff == FullCount);
   assign q_valid = (count_ff != '0);
   assign q_entry = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0
                     : wr_ptr_ff + pbrld_pkg::QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0
                     : rd_ptr_ff + pbrld_pkg::QUEUE_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + pbrld_pkg::QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - pbrld_pkg::QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/pbrld_back.sv @@
// ----------------------------------------------------------------------------
// PackBits decoder back end
// Turns queue entries into result fields and holds them in the output
// register until the consumer takes the item.
// ----------------------------------------------------------------------------
module pbrld_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  pbrld_pkg::entry_type q_entry,
   output logic                 pop,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_data_byte,
   output logic [7:0]           rsp_repeat_count,
   output logic                 rsp_row_last,
   output logic                 rsp_status,
   output logic [pbrld_pkg::CONSUMED_BITS-1:0] rsp_consumed_bytes
);

   logic                    valid_ff, valid_in;
   logic [7:0]              data_ff, data_in;
   logic [7:0]              count_ff, count_in;
   logic                    last_ff, last_in;
   logic                    status_ff, status_in;
   pbrld_pkg::consumed_type consumed_ff, consumed_in;
   logic                    is_err;

   assign pop    = q_valid && (!valid_ff || !rsp_stall);
   assign is_err = (q_entry.op == pbrld_pkg::OP_ERROR);

   always_comb begin
      valid_in    = valid_ff && rsp_stall;
      data_in     = data_ff;
      count_in    = count_ff;
      last_in     = last_ff;
      status_in   = status_ff;
      consumed_in = consumed_ff;
      if (pop) begin
         valid_in    = 1'b1;
         data_in     = is_err ? 8'd0 : q_entry.data_byte;
         count_in    = is_err ? 8'd0 : q_entry.repeat_count;
         last_in     = !is_err && q_entry.row_last;
         status_in   = is_err;
         consumed_in = q_entry.consumed_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      count_ff    <= count_in;
      last_ff     <= last_in;
      status_ff   <= status_in;
      consumed_ff <= consumed_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_data_byte      = data_ff;
   assign rsp_repeat_count   = count_ff;
   assign rsp_row_last       = last_ff;
   assign rsp_status         = status_ff;
   assign rsp_consumed_bytes = consumed_ff;

endmodule

@@ rtl/packbits_run_length_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// PackBits run-length decoder
// Takes one compressed byte per cycle unless stalled and gives at most one
// counted result (data byte, repeat count) per byte, with row completion and
// overflow errors.
// Accepts one code byte every cycle while req_stall is low; a byte that yields
// a result is queued at its accepting edge and shows on rsp_ when the output
// register loads. Control and skip bytes give no result, but an overflowing
// literal control byte gives an error. Results pass through a two-entry queue,
// so req_stall rises only once a stalled rsp_ result and two queued results
// wait. Write row_length via csr_ (always ready) between items; not checked.
module packbits_run_length_decoder_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_code_byte,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [pbrld_pkg::CSR_DATA_BITS-1:0] csr_row_length,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_data_byte,
   output logic [7:0]           rsp_repeat_count,
   output logic                 rsp_row_last,
   output logic                 rsp_status,
   output logic [pbrld_pkg::CONSUMED_BITS-1:0] rsp_consumed_bytes
);

`include "packbits_run_length_decoder_unit_assert.svh"

   logic                 push_valid;
   pbrld_pkg::entry_type push_entry;
   logic                 q_full;
   logic                 q_valid;
   pbrld_pkg::entry_type q_entry;
   logic                 pop;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   pbrld_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_byte  (req_code_byte),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_row_length (csr_row_length),
      .push_valid     (push_valid),
      .push_entry     (push_entry)
   );

   pbrld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .q_valid    (q_valid),
      .q_entry    (q_entry)
   );

   pbrld_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_entry            (q_entry),
      .pop                (pop),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_repeat_count   (rsp_repeat_count),
      .rsp_row_last       (rsp_row_last),
      .rsp_status         (rsp_status),
      .rsp_consumed_bytes (rsp_consumed_bytes)
   );

   `PBRLD_ASSERT_NOW(a_no_push_when_full, clock, reset, push_valid, !q_full, "item pushed into full queue")
   `PBRLD_ASSERT_NOW(a_rsp_from_queue, clock, reset, $rose(rsp_valid), $past(q_valid), "result appeared without a queued entry")
   `PBRLD_ASSERT_NEXT(a_pop_loads_rsp, clock, reset, pop, rsp_valid, "popped entry not presented")

endmodule

@@ bench/tb_packbits_run_length_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// PackBits run-length decoder testbench
// Drives compressed rows, overflow runs, skip codes and noise through the
// decoder under random idle and stall. Expected results come from a
// cycle-free model of the row state and are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_packbits_run_length_decoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import pbrld_pkg::*;

   localparam logic       STATUS_OK       = 1'b0;
   localparam logic       STATUS_OVERFLOW = 1'b1;
   localparam logic [7:0] LITERAL_MAX     = 8'd127;
   localparam int         SETTLE_CYCLES   = 4;
   localparam int         RANDOM_ITEMS    = 1950;

   typedef struct packed {
      logic [7:0]   data_byte;
      logic [7:0]   repeat_count;
      logic         row_last;
      logic         status;
      consumed_type consumed_bytes;
   } decoded_run_type;

   class row_decode_checker;
      row_len_type     row_len;
      phase_type       phase;
      logic [7:0]      run_left;
      int unsigned     written;
      consumed_type    consumed;
      decoded_run_type expected_runs[$];
      int              error_count;

      function new();
         row_len = 16'd1;
         error_count = 0;
         restart_row();
      endfunction

      function void restart_row();
         phase = PH_CONTROL;
         run_left = 8'd0;
         written = 0;
         consumed = '0;
      endfunction

      function void set_row_length(row_len_type value);
         row_len = value;
      endfunction

      function void emit_run(logic [7:0] data, int unsigned len);
         decoded_run_type r;
         written += len;
         r.data_byte = data;
         r.repeat_count = len[7:0];
         r.row_last = (written == row_len);
         r.status = STATUS_OK;
         r.consumed_bytes = consumed;
         expected_runs.push_back(r);
         if (r.row_last) restart_row();
      endfunction

      function void emit_overflow();
         decoded_run_type r;
         r.data_byte = 8'd0;
         r.repeat_count = 8'd0;
         r.row_last = 1'b0;
         r.status = STATUS_OVERFLOW;
         r.consumed_bytes = consumed;
         expected_runs.push_back(r);
         restart_row();
      endfunction

      // called for every accepted code byte
      function void take_code_byte(logic [7:0] b);
         int unsigned len;
         if (consumed != CONSUMED_MAX) consumed++;
         case (phase)
            PH_LITERAL: begin
               run_left = run_left - 8'd1;
               if (run_left == 8'd0) phase = PH_CONTROL;
               emit_run(b, 1);
            end
            PH_REPEAT: begin
               len = run_left;
               phase = PH_CONTROL;
               run_left = 8'd0;
               if (written + len > row_len) emit_overflow();
               else emit_run(b, len);
            end
            default: begin
               phase = PH_CONTROL;
               if (b <= LITERAL_MAX) begin
                  len = b + 1;
                  if (written + len > row_len) begin
                     emit_overflow();
                  end else begin
                     phase = PH_LITERAL;
                     run_left = len[7:0];
                  end
               end else if (b != SKIP_CODE) begin
                  len = REPEAT_BASE - b;
                  phase = PH_REPEAT;
                  run_left = len[7:0];
               end
            end
         endcase
      endfunction

      task flag_mismatch(string msg);
         $display("ERROR at %0t: %s", $realtime, msg);
         error_count++;
      endtask

      task compare_field(string name, int got, int want);
         if (got !== want) flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task match_result(logic [7:0] data, logic [7:0] count, logic last, logic status,
                        consumed_type used);
         decoded_run_type want;
         if (expected_runs.size() == 0) begin
            flag_mismatch($sformatf("unexpected result data %0h count %0d", data, count));
         end else begin
            want = expected_runs.pop_front();
            compare_field("data_byte", int'(data), int'(want.data_byte));
            compare_field("repeat_count", int'(count), int'(want.repeat_count));
            compare_field("row_last", int'(last), int'(want.row_last));
            compare_field("status", int'(status), int'(want.status));
            compare_field("consumed_bytes", int'(used), int'(want.consumed_bytes));
         end
      endtask
   endclass

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_code_byte = 8'd0;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_DATA_BITS-1:0] csr_row_length = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [7:0]               rsp_data_byte;
   logic [7:0]               rsp_repeat_count;
   logic                     rsp_row_last;
   logic                     rsp_status;
   consumed_type             rsp_consumed_bytes;

   row_decode_checker sb = new();
   bit                quiet = 1'b0;
   int                accepted_items = 0;

   packbits_run_length_decoder_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_code_byte      (req_code_byte),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_row_length     (csr_row_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_repeat_count   (rsp_repeat_count),
      .rsp_row_last       (rsp_row_last),
      .rsp_status         (rsp_status),
      .rsp_consumed_bytes (rsp_consumed_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.match_result(rsp_data_byte, rsp_repeat_count, rsp_row_last, rsp_status,
                            rsp_consumed_bytes);
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 19);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (!quiet && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_code_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.take_code_byte(b);
      accepted_items++;
   endtask

   // stops early when the control byte overflows the row
   task automatic send_literal(input int n);
      send_byte(8'(n - 1));
      while (sb.phase == PH_LITERAL) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic send_repeat(input int n);
      send_byte(8'(REPEAT_BASE - n));
      send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic send_run(input int n);
      if (n == 1 || $urandom_range(0, 1) == 0) send_literal(n);
      else send_repeat(n);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_runs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_row_length(input logic [CSR_DATA_BITS-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_row_length <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_row_length(value);
   endtask

   // well-formed runs toward the end of the row; broken rows may end in an overflow
   task automatic drive_row(input bit broken, input int max_runs);
      int left;
      int n;
      int cap;
      while (sb.phase != PH_CONTROL) send_byte(8'($urandom_range(0, 255)));
      left = int'(sb.row_len) - int'(sb.written);
      if (left <= 0) begin
         send_literal(1);
         left = int'(sb.row_len);
      end
      if (left == 0) begin
         send_run(int'($urandom_range(1, 128)));
         return;
      end
      for (int r = 0; r < max_runs && left > 0 && accepted_items < RANDOM_ITEMS; r++) begin
         if ($urandom_range(0, 15) == 0) send_byte(SKIP_CODE);
         if (broken && left < 128 && $urandom_range(0, 3) == 0) begin
            cap = (left + 6 < 128) ? left + 6 : 128;
            send_run(int'($urandom_range(left + 1, cap)));
            return;
         end
         cap = (left < 128) ? left : 128;
         if ($urandom_range(0, 2) == 0) n = $urandom_range(1, cap);
         else n = $urandom_range(1, (cap < 6) ? cap : 6);
         send_run(n);
         left -= n;
      end
   endtask

   initial begin
      logic [CSR_DATA_BITS-1:0] len;
      int sel;
      int kind;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // row length 1 after reset
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(LITERAL_MAX);
      send_byte(SKIP_CODE);
      send_byte(8'h00);
      send_byte(8'hA5);

      write_row_length(16'd0);
      send_byte(8'h00);
      send_byte(8'h81);
      send_byte(8'h5A);

      write_row_length(16'd130);
      send_byte(8'h81);
      send_byte(8'h3C);
      send_byte(8'h01);
      send_byte(8'h00);
      send_byte(8'hFF);

      // shrink the row while a literal run is open
      send_byte(8'h02);
      wait_idle();
      write_row_length(16'd2);
      send_byte(8'h10);
      send_byte(8'h20);
      send_byte(SKIP_CODE);

      accepted_items = 0;
      while (accepted_items < RANDOM_ITEMS) begin
         quiet = (accepted_items >= 700 && accepted_items < 1000);
         sel = $urandom_range(0, 19);
         if (sel < 12) len = 16'($urandom_range(1, 8));
         else if (sel < 16) len = 16'($urandom_range(9, 300));
         else if (sel == 16) len = 16'd0;
         else if (sel == 17) len = 16'hFFFF;
         else len = 16'($urandom_range(0, 65535));
         write_row_length(len);
         repeat ($urandom_range(1, 6)) begin
            if (accepted_items < RANDOM_ITEMS) begin
               kind = $urandom_range(0, 9);
               if (kind < 7) drive_row(1'b0, 40);
               else if (kind < 9) drive_row(1'b1, 40);
               else repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
            end
         end
      end
      quiet = 1'b0;

      wait_idle();
      if (sb.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ packbits_run_length_decoder_unit.f @@
+incdir+rtl
rtl/pbrld_pkg.sv
rtl/pbrld_front.sv
rtl/pbrld_queue.sv
rtl/pbrld_back.sv
rtl/packbits_run_length_decoder_unit.sv
bench/tb_packbits_run_length_decoder_unit.sv
